@@ rtl/core/tbpc_pkg.sv @@
package tbpc_pkg;

    localparam int NUM_BUTTONS = 2;
    localparam int HOLD_WIDTH  = 20;
    localparam int DBC_W       = 8;
    localparam int LONG_W      = 20;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_IDX_W   = 1;
    localparam int CMP_W       = (HOLD_WIDTH > LONG_W) ? HOLD_WIDTH : LONG_W;

    localparam logic [HOLD_WIDTH-1:0] HOLD_MAX = {HOLD_WIDTH{1'b1}};

    localparam logic [DBC_W-1:0]  DEBOUNCE_RESET = DBC_W'(30);
    localparam logic [LONG_W-1:0] LONG_RESET     = LONG_W'(3000);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG     = 1'b1;

    // per-button mode
    localparam logic [1:0] MODE_IDLE     = 2'd0;
    localparam logic [1:0] MODE_DEBOUNCE = 2'd1;
    localparam logic [1:0] MODE_HELD     = 2'd2;

    // reported status
    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_FIRST    = 2'd1;
    localparam logic [1:0] ST_HELD     = 2'd2;
    localparam logic [1:0] ST_RELEASED = 2'd3;

    // reported event
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_SHORT = 2'd1;
    localparam logic [1:0] EV_LONG  = 2'd2;

    typedef struct packed {
        logic [DBC_W-1:0]  debounce_ticks;
        logic [LONG_W-1:0] long_press_ticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] event_code;
    } t_lane_res;

endpackage

@@ rtl/core/tbpc_if.sv @@
interface tbpc_in_if;
    logic valid;
    logic ready;
    logic button_one_pin;
    logic button_two_pin;

    modport source (output valid, output button_one_pin, output button_two_pin, input ready);
    modport sink   (input valid, input button_one_pin, input button_two_pin, output ready);
endinterface

interface tbpc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] button_one_status;
    logic [1:0] button_one_event;
    logic [1:0] button_two_status;
    logic [1:0] button_two_event;

    modport source (output valid, output button_one_status, output button_one_event,
                    output button_two_status, output button_two_event, input ready);
    modport sink   (input valid, input button_one_status, input button_one_event,
                    input button_two_status, input button_two_event, output ready);
endinterface

@@ rtl/core/two_button_press_classifier_unit.sv @@
// Two-button press classifier. Each request is one sample of two active-low
// button pins; each request yields one result with a status and an event per
// button. One request is taken every clock while the skid is empty; its
// result goes to the output register, or to the skid while the output stalls.
// The rate is set by the per-button lane, which updates its mode, debounce
// counter and saturating hold counter, and a two-entry output stage (register
// plus skid) keeps input flowing while a result waits. Write debounce_ticks
// (index 0) and long_press_ticks (index 1) only while no request is in flight.
module two_button_press_classifier_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tbpc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tbpc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    tbpc_in_if.sink                             i_in,
    tbpc_out_if.source                          o_out
);
    import tbpc_pkg::*;

    t_cfg      r_cfg;
    t_lane_res lane_res [NUM_BUTTONS];
    logic      pins [NUM_BUTTONS];
    logic      ready;
    logic      take;

    assign pins[0]    = i_in.button_one_pin;
    assign pins[1]    = i_in.button_two_pin;
    assign i_in.ready = ready;
    assign take       = i_in.valid & ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks   <= DEBOUNCE_RESET;
            r_cfg.long_press_ticks <= LONG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DEBOUNCE: r_cfg.debounce_ticks   <= i_cfg_data[DBC_W-1:0];
                REG_LONG:     r_cfg.long_press_ticks <= i_cfg_data[LONG_W-1:0];
                default: ;
            endcase
        end
    end

    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        tbpc_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (take),
            .i_pin   (pins[g]),
            .i_cfg   (r_cfg),
            .o_res   (lane_res[g])
        );
    end

    tbpc_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_res   (lane_res),
        .o_ready (ready),
        .o_out   (o_out)
    );

endmodule

@@ rtl/core/tbpc_lane.sv @@
module tbpc_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_pin,
    input  tbpc_pkg::t_cfg     i_cfg,
    output tbpc_pkg::t_lane_res o_res
);
    import tbpc_pkg::*;

    logic [1:0]            r_mode, n_mode;
    logic [DBC_W-1:0]      r_dbc, n_dbc;
    logic [HOLD_WIDTH-1:0] r_hold, n_hold;
    logic [HOLD_WIDTH-1:0] hold_inc;
    logic                  pin_low;

    assign pin_low  = ~i_pin;
    assign hold_inc = (r_hold != HOLD_MAX) ? r_hold + HOLD_WIDTH'(1) : r_hold;

    always_comb begin
        n_mode           = r_mode;
        n_dbc            = r_dbc;
        n_hold           = r_hold;
        o_res.status     = ST_IDLE;
        o_res.event_code = EV_NONE;
        unique case (r_mode)
            MODE_DEBOUNCE: begin
                if (r_dbc > DBC_W'(1)) begin
                    n_dbc = r_dbc - DBC_W'(1);
                end else begin
                    n_dbc = '0;
                    if (pin_low) begin
                        n_mode       = MODE_HELD;
                        n_hold       = '0;
                        o_res.status = ST_FIRST;
                    end else begin
                        n_mode = MODE_IDLE;
                    end
                end
            end
            MODE_HELD: begin
                n_hold = hold_inc;
                if (pin_low) begin
                    o_res.status = ST_HELD;
                end else begin
                    o_res.status     = ST_RELEASED;
                    o_res.event_code = (CMP_W'(hold_inc) > CMP_W'(i_cfg.long_press_ticks))
                                       ? EV_LONG : EV_SHORT;
                    n_mode           = MODE_IDLE;
                end
            end
            default: begin
                n_mode = MODE_IDLE;
                if (pin_low) begin
                    if (i_cfg.debounce_ticks == '0) begin
                        // zero debounce: confirm on the press sample itself
                        n_dbc        = '0;
                        n_mode       = MODE_HELD;
                        n_hold       = '0;
                        o_res.status = ST_FIRST;
                    end else begin
                        n_mode = MODE_DEBOUNCE;
                        n_dbc  = i_cfg.debounce_ticks;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_dbc  <= '0;
            r_hold <= '0;
        end else if (i_adv) begin
            r_mode <= n_mode;
            r_dbc  <= n_dbc;
            r_hold <= n_hold;
        end
    end

    a_release_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.status == ST_RELEASED) == (o_res.event_code != EV_NONE))
        else $error("event without release or release without event");

    a_event_from_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.event_code != EV_NONE) |-> (r_mode == MODE_HELD))
        else $error("event reported outside held mode");

    a_debounce_countdown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && r_mode == MODE_DEBOUNCE && r_dbc > DBC_W'(1)) |=>
        (r_mode == MODE_DEBOUNCE && r_dbc == $past(r_dbc) - DBC_W'(1)))
        else $error("debounce countdown did not advance");

endmodule

@@ rtl/core/tbpc_merge.sv @@
module tbpc_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  tbpc_pkg::t_lane_res i_res [tbpc_pkg::NUM_BUTTONS],
    output logic                o_ready,
    tbpc_out_if.source          o_out
);
    import tbpc_pkg::*;

    typedef struct packed {
        t_lane_res one;
        t_lane_res two;
    } t_result;

    t_result r_out, r_skid, in_word;
    logic    r_valid, r_skid_valid;

    assign in_word.one = i_res[0];
    assign in_word.two = i_res[1];
    assign o_ready     = ~r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_valid || o_out.ready) begin
            // output register moves: drain skid first
            if (r_skid_valid) begin
                r_valid      <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_valid <= i_take;
            end
        end else if (i_take) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_valid || o_out.ready) begin
            r_out <= r_skid_valid ? r_skid : in_word;
        end else if (i_take) begin
            r_skid <= in_word;
        end
    end

    assign o_out.valid             = r_valid;
    assign o_out.button_one_status = r_out.one.status;
    assign o_out.button_one_event  = r_out.one.event_code;
    assign o_out.button_two_status = r_out.two.status;
    assign o_out.button_two_event  = r_out.two.event_code;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_valid)
        else $error("skid holds a request while output is empty");

    a_no_take_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_take)
        else $error("request taken with skid full");

endmodule
